@@ hw/rtl/tccw_pkg.sv @@
// shared types, constants and helper functions for the text console char writer
// no dependencies
package tccw_pkg;

  localparam int DEF_MAX_COLUMNS = 80;
  localparam int DEF_MAX_ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN  = 3'd4;

  localparam logic [COL_W-1:0]  RESET_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]  RESET_ROWS    = 5'd25;
  localparam logic [ATTR_W-1:0] RESET_ATTR    = 8'd7;
  localparam logic [CHAR_W-1:0] RESET_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] RESET_RETURN  = 8'd13;

  localparam logic [COL_W-1:0] CURSOR_COL_RESET = 7'd8;
  localparam logic [ROW_W-1:0] CURSOR_ROW_RESET = 5'd8;

  localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'd32;
  localparam logic [CHAR_W-1:0] DEL_CODE   = 8'd127;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;

  typedef struct packed {
    logic clear_step;
    logic scroll_step;
    logic cnt_reset;
    logic accept;
    logic write_cell;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scroll_done;
    logic in_read;
    logic in_scroll;
  } dp_status_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int count_bits(int depth);
    return $clog2(depth + 1);
  endfunction

endpackage

@@ hw/rtl/text_console_char_writer.sv @@
// text console char writer top level: stream ports, controller and datapath
// depends on tccw_pkg, tccw_ctrl, tccw_datapath
// results: puts from the write state, reads from the read data state (registered ram read)
// one word at a time: a new word is accepted only in idle, after the last one is done
// a put that scrolls first moves the screen up a row, one cell copy per cycle on the ram port
// reset: synchronous; then a clearing pass of all MAX_COLUMNS*MAX_ROWS cells, s_tready low
// config writes are taken in any cycle outside reset
module text_console_char_writer
  import tccw_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // char_code, move_cursor, read_row, read_column
  input  logic [S_DATA_W-1:0]   s_tdata,
  // kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cell_char, cell_attr, cursor_moved, cursor_report_column, cursor_report_row,
  // scrolled, cursor_column, cursor_row
  output logic [M_DATA_W-1:0]   m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_move   (s_tdata[8]),
    .in_row    (s_tdata[13:9]),
    .in_col    (s_tdata[20:14]),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata)
  );

endmodule

@@ hw/rtl/tccw_ram.sv @@
// generic simple dual port ram, one write port, one registered read port
// depends on tccw_pkg
module tccw_ram
  import tccw_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_MAX_COLUMNS * DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [addr_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]            wdata,
  input  logic [addr_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tccw_ctrl.sv @@
// controller state machine: clearing pass, item sequencing, output word valid
// depends on tccw_pkg
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_WRITE,
    ST_READ,
    ST_RDATA
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          cmd.cnt_reset = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.in_read) begin
            state_next = ST_READ;
          end else if (status.in_scroll) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.scroll_done) begin
          cmd.cnt_reset = 1'b1;
          state_next    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.write_cell = 1'b1;
          cmd.load_out   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/tccw_datapath.sv @@
// datapath: config registers, cursor, cell address, sweep counter, cell ram, output word
// depends on tccw_pkg and tccw_ram
module tccw_datapath
  import tccw_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_kind,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_move,
  input  logic [ROW_W-1:0]      in_row,
  input  logic [COL_W-1:0]      in_col,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [M_DATA_W-1:0]   out_data
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = addr_bits(DEPTH);
  localparam int CNT_W  = count_bits(DEPTH);
  localparam int PROD_W = COL_W + ROW_W;

  logic [COL_W-1:0]  cfg_cols;
  logic [ROW_W-1:0]  cfg_rows;
  logic [ATTR_W-1:0] text_attr;
  logic [CHAR_W-1:0] newline_code;
  logic [CHAR_W-1:0] return_code;

  logic [COL_W-1:0] width;
  logic [ROW_W-1:0] height;

  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;

  logic              line_break;
  logic              wrap;
  logic [ROW_W:0]    row_step;
  logic              need_scroll;
  logic [COL_W-1:0]  col_f;
  logic [ROW_W-1:0]  row_f;
  logic              read_ok;
  logic              printable;
  logic [ROW_W-1:0]  row_sel;
  logic [COL_W-1:0]  col_sel;
  logic [PROD_W-1:0] prod;

  logic              it_kind;
  logic              it_move;
  logic [CHAR_W-1:0] it_char;
  logic              it_print;
  logic              it_scroll;
  logic [COL_W-1:0]  it_col;
  logic [ROW_W-1:0]  it_row;
  logic              it_ok;
  logic [ADDR_W-1:0] addr_reg;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] area;
  logic [CNT_W-1:0] moved;
  logic             copy_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [CHAR_W-1:0] out_char;
  logic [ATTR_W-1:0] out_attr;
  logic              out_moved;
  logic [COL_W-1:0]  out_rep_col;
  logic [ROW_W-1:0]  out_rep_row;
  logic              out_scrolled;
  logic [COL_W-1:0]  out_cur_col;
  logic [ROW_W-1:0]  out_cur_row;
  logic [COL_W-1:0]  col_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols     <= RESET_COLUMNS;
      cfg_rows     <= RESET_ROWS;
      text_attr    <= RESET_ATTR;
      newline_code <= RESET_NEWLINE;
      return_code  <= RESET_RETURN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cfg_cols     <= cfg_data[COL_W-1:0];
        CFG_ROWS:    cfg_rows     <= cfg_data[ROW_W-1:0];
        CFG_ATTR:    text_attr    <= cfg_data[ATTR_W-1:0];
        CFG_NEWLINE: newline_code <= cfg_data[CHAR_W-1:0];
        CFG_RETURN:  return_code  <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry in use, zero taken as one, saturated to the screen store
  always_comb begin
    if (cfg_cols == '0) begin
      width = COL_W'(1);
    end else if (int'(cfg_cols) > MAX_COLUMNS) begin
      width = COL_W'(MAX_COLUMNS);
    end else begin
      width = cfg_cols;
    end
    if (cfg_rows == '0) begin
      height = ROW_W'(1);
    end else if (int'(cfg_rows) > MAX_ROWS) begin
      height = ROW_W'(MAX_ROWS);
    end else begin
      height = cfg_rows;
    end
  end

  // put and read decode, from the incoming word and the cursor
  always_comb begin
    line_break  = (in_char == newline_code) || (in_char == return_code);
    wrap        = !line_break && (cursor_col >= width);
    row_step    = {1'b0, cursor_row} + (ROW_W + 1)'(line_break || wrap);
    need_scroll = row_step >= {1'b0, height};
    col_f       = (line_break || wrap || need_scroll) ? '0 : cursor_col;
    row_f       = need_scroll ? (height - ROW_W'(1)) : row_step[ROW_W-1:0];
    read_ok     = (in_row < height) && (in_col < width);
    printable   = !((in_char < CTRL_LIMIT) || (in_char == DEL_CODE));
    row_sel     = (in_kind == KIND_READ) ? in_row : row_f;
    col_sel     = (in_kind == KIND_READ) ? in_col : col_f;
    prod        = PROD_W'(PROD_W'(row_sel) * PROD_W'(width)) + PROD_W'(col_sel);
  end

  assign status.in_read     = (in_kind == KIND_READ);
  assign status.in_scroll   = need_scroll;
  assign status.clear_done  = (cnt == CNT_W'(DEPTH - 1));
  assign status.scroll_done = (cnt == area);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_kind   <= in_kind;
      it_move   <= in_move;
      it_char   <= in_char;
      it_print  <= printable;
      it_scroll <= need_scroll;
      it_col    <= col_f;
      it_row    <= row_f;
      it_ok     <= read_ok;
      addr_reg  <= ((in_kind == KIND_PUT) || read_ok) ? ADDR_W'(prod) : '0;
    end
  end

  // sweep counter for the clearing pass and the scroll copy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_reset) begin
      cnt <= '0;
    end else if (cmd.clear_step || cmd.scroll_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    area <= CNT_W'(PROD_W'(width) * PROD_W'(height));
    if (cmd.scroll_step) begin
      copy_d <= (cnt < moved);
    end
  end

  assign moved = area - CNT_W'(width);

  // scroll: read cell k plus width, write it at k in the next cycle; the last row is written blank
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_reg;
    ram_wdata = {text_attr, it_char};
    ram_raddr = addr_reg;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[ADDR_W-1:0];
      ram_wdata = '0;
    end else if (cmd.scroll_step) begin
      ram_we    = (cnt != '0);
      ram_waddr = ADDR_W'(cnt - CNT_W'(1));
      ram_wdata = copy_d ? ram_rdata : '0;
      ram_raddr = (cnt < moved) ? ADDR_W'(cnt + CNT_W'(width)) : '0;
    end else if (cmd.write_cell) begin
      ram_we = it_print;
    end
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign col_after = it_col + COL_W'(it_print);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= CURSOR_COL_RESET;
      cursor_row <= CURSOR_ROW_RESET;
    end else if (cmd.load_out && (it_kind == KIND_PUT)) begin
      cursor_col <= col_after;
      cursor_row <= it_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (it_kind == KIND_READ) begin
        out_char     <= it_ok ? ram_rdata[CHAR_W-1:0] : '0;
        out_attr     <= it_ok ? ram_rdata[CELL_W-1:CHAR_W] : '0;
        out_moved    <= 1'b0;
        out_rep_col  <= '0;
        out_rep_row  <= '0;
        out_scrolled <= 1'b0;
        out_cur_col  <= cursor_col;
        out_cur_row  <= cursor_row;
      end else begin
        out_char     <= '0;
        out_attr     <= '0;
        out_moved    <= it_move;
        out_rep_col  <= it_move ? (it_col + COL_W'(1)) : '0;
        out_rep_row  <= it_move ? it_row : '0;
        out_scrolled <= it_scroll;
        out_cur_col  <= col_after;
        out_cur_row  <= it_row;
      end
    end
  end

  assign out_data = {6'b0, out_cur_row, out_cur_col, out_scrolled, out_rep_row,
                     out_rep_col, out_moved, out_attr, out_char};

endmodule

@@ hw/rtl/tccw_checker.sv @@
// port level checks for the text console char writer, bound to the top level
// depends on tccw_pkg
module tccw_checker
  import tccw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // no cursor report means zero report fields
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> m_tdata[28:17] == 12'd0)
    else $error("report fields set without a cursor report");

  // a reported column is the column plus one, never zero
  a_report_col: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tdata[23:17] != 7'd0)
    else $error("reported cursor column is zero");

  // a word with cell data comes from a read, which neither reports nor scrolls
  a_read_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:0] != 16'd0) |-> !m_tdata[16] && !m_tdata[29])
    else $error("read word carries put flags");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

endmodule

bind text_console_char_writer tccw_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
